>>> rtl/core/sfdm_pkg.sv
// Shared types, constants and coefficient tables for the six-channel
// FIR / delay mixer. No dependencies.
package sfdm_pkg;

  localparam int DEF_DELAY_DEPTH  = 32768;
  localparam int DEF_CHANNELS     = 6;
  localparam int DEF_SAMPLE_WIDTH = 24;

  localparam int MAX_CH     = 6;
  localparam int CH_W       = 3;
  localparam int TAPS       = 31;
  localparam int TAP_W      = 5;
  localparam int GAIN_W     = 17;
  localparam int LEN_W      = 15;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 15;

  localparam logic signed [GAIN_W-1:0] GL_PRE  = 17'sd53270;
  localparam logic signed [GAIN_W-1:0] GL_POST = 17'sd57079;
  localparam logic signed [GAIN_W-1:0] GR_PRE  = 17'sd52057;
  localparam logic signed [GAIN_W-1:0] GR_POST = 17'sd50742;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EN_MASK   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DLY_MASK  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DLY_SEL   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIR_SEL   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DLY_SHORT = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DLY_MED   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DLY_LONG  = 4'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS  = 4'd8;

  // delay select codes
  localparam logic [1:0] DSEL_NONE  = 2'd0;
  localparam logic [1:0] DSEL_SHORT = 2'd1;
  localparam logic [1:0] DSEL_MED   = 2'd2;
  localparam logic [1:0] DSEL_LONG  = 2'd3;

  // half of each symmetric 31-tap set, center tap last
  localparam int COEF_HALF [4][16] = '{
    '{-192, -189, -164, -108, -9, 148, 380, 709, 1157, 1752, 2522, 3497, 4706, 6178,
      7936, 8889},
    '{-69, -112, -164, -222, -277, -310, -293, -184, 80, 579, 1421, 2735, 4668, 7377,
      11006, 13067},
    '{16, 10, -8, -45, -106, -196, -305, -405, -435, -277, 261, 1463, 3715, 7483,
      13252, 16696},
    '{6, 12, 19, 23, 15, -21, -103, -244, -429, -578, -481, 281, 2409, 6904, 14950,
      20012}
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_PRE_L, ST_PRE_R, ST_PRE_W, ST_CH_SEL,
    ST_DLY_WR, ST_DLY_RD, ST_DLY_WAIT, ST_DLY_ST,
    ST_FIR_CHK, ST_FIR_WR, ST_FIR_TAP, ST_DRAIN1, ST_DRAIN2,
    ST_FIR_RND, ST_FIR_POST, ST_RP_ST, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_LPRE, MUL_RPRE, MUL_DPOST, MUL_RPOST
  } mul_sel_t;

  typedef struct packed {
    logic             in_load;
    logic [CH_W-1:0]  ch;
    mul_sel_t         mul_sel;
    logic             st_lpre;
    logic             st_rpre;
    logic             lp_pass;
    logic             st_lp;
    logic             dly_wr;
    logic             dly_rd;
    logic             fir_wr;
    logic             tap_rd;
    logic [TAP_W-1:0] tap;
    logic             fir_rnd;
    logic             st_rp;
    logic             rp_zero;
    logic             out_load;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/six_channel_fir_delay_mixer.sv
// Top level of the six-channel FIR / delay mixer: configuration registers,
// sequencer and datapath. Depends on sfdm_pkg, sfdm_ctrl, sfdm_dp.
//
// One stereo pair per input beat gives one output beat per enabled channel,
// in ascending channel order, with last on the highest one. Each item first
// applies the left and right input gains, then, for each enabled channel,
// the delay path (where enabled) and, when the right input is present, the
// 31-tap MAC, which runs one tap a cycle through the history memory read
// port and the single shared multiplier. A new input beat is stalled until
// the item is finished, and output stalls hold the sequencer. Every valid
// configuration write clears the delays and FIR histories; the block stalls
// its input in the cycle after the write (and after reset) while the pointers
// reload. Delay and history memories are not swept: fill tracking makes
// unwritten entries read as zero.
module six_channel_fir_delay_mixer #(
  parameter int DELAY_DEPTH  = sfdm_pkg::DEF_DELAY_DEPTH,
  parameter int CHANNELS     = sfdm_pkg::DEF_CHANNELS,
  parameter int SAMPLE_WIDTH = sfdm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_right_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sfdm_pkg::CH_W-1:0]           out_channel,
  output logic signed [SAMPLE_WIDTH-1:0]      out_mixed_sample,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfdm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [sfdm_pkg::MAX_CH-1:0]   en_mask_r, dly_mask_r;
  logic [2*sfdm_pkg::MAX_CH-1:0] dly_sel_r, fir_sel_r;
  logic [1:0]                    in_count_r;
  logic [sfdm_pkg::LEN_W-1:0]    dly_short_r, dly_med_r, dly_long_r;
  logic                          clr_r, clr_nxt;
  logic                          cfg_wr;
  sfdm_pkg::cmd_t                cmd;
  sfdm_pkg::stat_t               stat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign clr_nxt   = cfg_wr && (cfg_index < sfdm_pkg::CFG_NUM_REGS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_mask_r   <= 6'd63;
      dly_mask_r  <= 6'd63;
      dly_sel_r   <= 12'd0;
      fir_sel_r   <= 12'd2730;
      in_count_r  <= 2'd2;
      dly_short_r <= 15'd7200;
      dly_med_r   <= 15'd14400;
      dly_long_r  <= 15'd21600;
      clr_r       <= 1'b1;
    end else begin
      clr_r <= clr_nxt;
      if (cfg_wr) begin
        case (cfg_index)
          sfdm_pkg::CFG_EN_MASK:   en_mask_r   <= cfg_data[5:0];
          sfdm_pkg::CFG_DLY_MASK:  dly_mask_r  <= cfg_data[5:0];
          sfdm_pkg::CFG_DLY_SEL:   dly_sel_r   <= cfg_data[11:0];
          sfdm_pkg::CFG_FIR_SEL:   fir_sel_r   <= cfg_data[11:0];
          sfdm_pkg::CFG_IN_COUNT:  in_count_r  <= cfg_data[1:0];
          sfdm_pkg::CFG_DLY_SHORT: dly_short_r <= cfg_data;
          sfdm_pkg::CFG_DLY_MED:   dly_med_r   <= cfg_data;
          sfdm_pkg::CFG_DLY_LONG:  dly_long_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  sfdm_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .clr      (clr_r),
    .en_mask  (en_mask_r),
    .dly_mask (dly_mask_r),
    .right_on (in_count_r[1]),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfdm_dp #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .CHANNELS    (CHANNELS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .clr             (clr_r),
    .in_left         (in_left_sample),
    .in_right        (in_right_sample),
    .left_on         (in_count_r != 2'd0),
    .right_on        (in_count_r[1]),
    .fir_sel         (fir_sel_r),
    .dly_sel         (dly_sel_r),
    .dly_short       (dly_short_r),
    .dly_med         (dly_med_r),
    .dly_long        (dly_long_r),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel     (out_channel),
    .out_mixed_sample(out_mixed_sample),
    .out_last        (out_last)
  );

endmodule

>>> rtl/core/sfdm_ctrl.sv
// Sequencer for the mixer: walks the channels and steps the datapath.
// Depends on sfdm_pkg.
module sfdm_ctrl #(
  parameter int CHANNELS = sfdm_pkg::DEF_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        clr,
  input  logic [sfdm_pkg::MAX_CH-1:0] en_mask,
  input  logic [sfdm_pkg::MAX_CH-1:0] dly_mask,
  input  logic                        right_on,
  input  sfdm_pkg::stat_t             stat,
  output sfdm_pkg::cmd_t              cmd
);

  localparam int CW = $clog2(CHANNELS + 1);
  localparam logic [sfdm_pkg::MAX_CH-1:0] CH_MASK =
    sfdm_pkg::MAX_CH'((1 << CHANNELS) - 1);

  sfdm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] ch_r, ch_nxt;
  logic [sfdm_pkg::TAP_W-1:0] tap_r, tap_nxt;
  logic [sfdm_pkg::MAX_CH-1:0] en_eff, upper;
  logic [sfdm_pkg::CH_W-1:0] chx;
  logic is_last;

  assign en_eff   = en_mask & CH_MASK;
  assign chx      = sfdm_pkg::CH_W'(ch_r);
  assign upper    = en_eff >> (chx + 3'd1);
  assign is_last  = (upper == '0);
  assign in_stall = (state_r != sfdm_pkg::ST_IDLE) || clr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfdm_pkg::ST_IDLE;
      ch_r    <= '0;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    tap_nxt      = tap_r;
    cmd          = '0;
    cmd.ch       = chx;
    cmd.tap      = tap_r;
    cmd.mul_sel  = sfdm_pkg::MUL_LPRE;
    case (state_r)
      sfdm_pkg::ST_IDLE: begin
        if (in_valid && !clr) begin
          cmd.in_load = 1'b1;
          ch_nxt      = '0;
          state_nxt   = sfdm_pkg::ST_PRE_L;
        end
      end
      sfdm_pkg::ST_PRE_L: begin
        cmd.mul_sel = sfdm_pkg::MUL_LPRE;
        state_nxt   = sfdm_pkg::ST_PRE_R;
      end
      sfdm_pkg::ST_PRE_R: begin
        cmd.mul_sel = sfdm_pkg::MUL_RPRE;
        cmd.st_lpre = 1'b1;
        state_nxt   = sfdm_pkg::ST_PRE_W;
      end
      sfdm_pkg::ST_PRE_W: begin
        cmd.st_rpre = 1'b1;
        state_nxt   = sfdm_pkg::ST_CH_SEL;
      end
      sfdm_pkg::ST_CH_SEL: begin
        if (ch_r == CW'(CHANNELS)) begin
          state_nxt = sfdm_pkg::ST_IDLE;
        end else if (!en_eff[chx]) begin
          ch_nxt = ch_r + 1'b1;
        end else if (dly_mask[chx]) begin
          state_nxt = sfdm_pkg::ST_DLY_WR;
        end else begin
          cmd.lp_pass = 1'b1;
          state_nxt   = sfdm_pkg::ST_FIR_CHK;
        end
      end
      sfdm_pkg::ST_DLY_WR: begin
        cmd.dly_wr = 1'b1;
        state_nxt  = sfdm_pkg::ST_DLY_RD;
      end
      sfdm_pkg::ST_DLY_RD: begin
        cmd.dly_rd = 1'b1;
        state_nxt  = sfdm_pkg::ST_DLY_WAIT;
      end
      sfdm_pkg::ST_DLY_WAIT: begin
        cmd.mul_sel = sfdm_pkg::MUL_DPOST;
        state_nxt   = sfdm_pkg::ST_DLY_ST;
      end
      sfdm_pkg::ST_DLY_ST: begin
        cmd.st_lp = 1'b1;
        state_nxt = sfdm_pkg::ST_FIR_CHK;
      end
      sfdm_pkg::ST_FIR_CHK: begin
        if (right_on) begin
          state_nxt = sfdm_pkg::ST_FIR_WR;
        end else begin
          cmd.rp_zero = 1'b1;
          state_nxt   = sfdm_pkg::ST_OUT;
        end
      end
      sfdm_pkg::ST_FIR_WR: begin
        cmd.fir_wr = 1'b1;
        tap_nxt    = '0;
        state_nxt  = sfdm_pkg::ST_FIR_TAP;
      end
      sfdm_pkg::ST_FIR_TAP: begin
        cmd.tap_rd = 1'b1;
        if (tap_r == sfdm_pkg::TAP_W'(sfdm_pkg::TAPS - 1)) begin
          state_nxt = sfdm_pkg::ST_DRAIN1;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      sfdm_pkg::ST_DRAIN1: state_nxt = sfdm_pkg::ST_DRAIN2;
      sfdm_pkg::ST_DRAIN2: state_nxt = sfdm_pkg::ST_FIR_RND;
      sfdm_pkg::ST_FIR_RND: begin
        cmd.fir_rnd = 1'b1;
        state_nxt   = sfdm_pkg::ST_FIR_POST;
      end
      sfdm_pkg::ST_FIR_POST: begin
        cmd.mul_sel = sfdm_pkg::MUL_RPOST;
        state_nxt   = sfdm_pkg::ST_RP_ST;
      end
      sfdm_pkg::ST_RP_ST: begin
        cmd.st_rp = 1'b1;
        state_nxt = sfdm_pkg::ST_OUT;
      end
      sfdm_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = is_last;
          ch_nxt       = ch_r + 1'b1;
          state_nxt    = sfdm_pkg::ST_CH_SEL;
        end
      end
      default: state_nxt = sfdm_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/sfdm_dp.sv
// Datapath: gains, delay memory, FIR history memory, shared multiplier,
// accumulator and output register. Depends on sfdm_pkg.
module sfdm_dp #(
  parameter int DELAY_DEPTH  = sfdm_pkg::DEF_DELAY_DEPTH,
  parameter int CHANNELS     = sfdm_pkg::DEF_CHANNELS,
  parameter int SAMPLE_WIDTH = sfdm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clr,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_left,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_right,
  input  logic                             left_on,
  input  logic                             right_on,
  input  logic [2*sfdm_pkg::MAX_CH-1:0]    fir_sel,
  input  logic [2*sfdm_pkg::MAX_CH-1:0]    dly_sel,
  input  logic [sfdm_pkg::LEN_W-1:0]       dly_short,
  input  logic [sfdm_pkg::LEN_W-1:0]       dly_med,
  input  logic [sfdm_pkg::LEN_W-1:0]       dly_long,
  input  sfdm_pkg::cmd_t                   cmd,
  output sfdm_pkg::stat_t                  stat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sfdm_pkg::CH_W-1:0]        out_channel,
  output logic signed [SAMPLE_WIDTH-1:0]   out_mixed_sample,
  output logic                             out_last
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int PW     = $clog2(DELAY_DEPTH);
  localparam int DAW    = $clog2(CHANNELS * DELAY_DEPTH);
  localparam int HDEPTH = CHANNELS * sfdm_pkg::TAPS;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PDW    = SW + sfdm_pkg::GAIN_W;
  localparam int ACW    = PDW + 5;
  localparam int SHW    = ACW - 16;
  localparam int TW     = sfdm_pkg::TAP_W;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0] dmem [CHANNELS*DELAY_DEPTH];
  logic signed [SW-1:0] hmem [HDEPTH];

  logic [PW-1:0] wptr_r [CHANNELS];
  logic [PW-1:0] rptr_r [CHANNELS];
  logic          full_r [CHANNELS];
  logic [TW-1:0] hp_r   [CHANNELS];
  logic [TW-1:0] hcnt_r [CHANNELS];

  logic signed [SW-1:0] left_r, right_r, lpre_r, rpre_r, lp_r, rp_r, fir_r;
  logic signed [SW-1:0] drd_r, hdata_r;
  logic                 dv_r, hv1_r;
  logic signed [sfdm_pkg::GAIN_W-1:0] coef1_r;
  logic [TW-1:0]        fslot_r;
  logic signed [PDW-1:0] prod_r;
  logic signed [ACW-1:0] acc_r;
  logic                 v1_r, v2_r;
  logic                 out_valid_r, out_last_r;
  logic [sfdm_pkg::CH_W-1:0] out_channel_r;
  logic signed [SW-1:0] out_mixed_r;

  logic [CIW-1:0]       ci;
  logic [DAW-1:0]       dwaddr, draddr;
  logic [HAW-1:0]       hwaddr, hraddr;
  logic [TW:0]          slot_ext;
  logic [TW-1:0]        kidx;
  logic [1:0]           fs;
  logic signed [SW-1:0] mul_a;
  logic signed [sfdm_pkg::GAIN_W-1:0] mul_b;
  logic signed [PDW-1:0] prod_rs;
  logic signed [SW-1:0] rnd_prod;
  logic signed [ACW-1:0] acc_rs;
  logic signed [SHW-1:0] acc_sh;
  logic signed [SW-1:0] fir_sat;
  logic signed [SW:0]   mix_sum;
  logic signed [SW-1:0] mix_sat;

  function automatic logic [PW-1:0] init_rptr(
    input logic [1:0] s,
    input logic [sfdm_pkg::LEN_W-1:0] ls,
    input logic [sfdm_pkg::LEN_W-1:0] lm,
    input logic [sfdm_pkg::LEN_W-1:0] ll
  );
    logic [16:0] len;
    logic [16:0] dep;
    dep = 17'(DELAY_DEPTH);
    case (s)
      sfdm_pkg::DSEL_SHORT: len = 17'(ls);
      sfdm_pkg::DSEL_MED:   len = 17'(lm);
      sfdm_pkg::DSEL_LONG:  len = 17'(ll);
      default:              len = '0;
    endcase
    if (len >= dep) len = dep - 17'd1;
    if (len == '0) return '0;
    return PW'(dep - len);
  endfunction

  assign ci     = cmd.ch[CIW-1:0];
  assign dwaddr = DAW'(int'(ci) * DELAY_DEPTH) + DAW'(wptr_r[ci]);
  assign draddr = DAW'(int'(ci) * DELAY_DEPTH) + DAW'(rptr_r[ci]);
  assign hwaddr = HAW'(int'(ci) * sfdm_pkg::TAPS) + HAW'(hp_r[ci]);
  // tap i sits i slots behind the newest sample, modulo the history length
  assign slot_ext = ({1'b0, fslot_r} >= {1'b0, cmd.tap}) ?
                    {1'b0, fslot_r} - {1'b0, cmd.tap} :
                    {1'b0, fslot_r} + (TW+1)'(sfdm_pkg::TAPS) - {1'b0, cmd.tap};
  assign hraddr = HAW'(int'(ci) * sfdm_pkg::TAPS) + HAW'(slot_ext[TW-1:0]);
  assign kidx   = (cmd.tap <= TW'(15)) ? cmd.tap : TW'(sfdm_pkg::TAPS - 1) - cmd.tap;
  assign fs     = fir_sel[{cmd.ch, 1'b0} +: 2];

  // pointer and fill state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wptr_r[c] <= '0;
        rptr_r[c] <= '0;
        full_r[c] <= 1'b0;
        hp_r[c]   <= '0;
        hcnt_r[c] <= '0;
      end
    end else if (clr) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wptr_r[c] <= '0;
        rptr_r[c] <= init_rptr(dly_sel[2*c +: 2], dly_short, dly_med, dly_long);
        full_r[c] <= 1'b0;
        hp_r[c]   <= '0;
        hcnt_r[c] <= '0;
      end
    end else begin
      if (cmd.dly_wr) begin
        if (wptr_r[ci] == PW'(DELAY_DEPTH - 1)) begin
          wptr_r[ci] <= '0;
          full_r[ci] <= 1'b1;
        end else begin
          wptr_r[ci] <= wptr_r[ci] + 1'b1;
        end
      end
      if (cmd.dly_rd) begin
        rptr_r[ci] <= (rptr_r[ci] == PW'(DELAY_DEPTH - 1)) ? '0 : rptr_r[ci] + 1'b1;
      end
      if (cmd.fir_wr) begin
        hp_r[ci] <= (hp_r[ci] == TW'(sfdm_pkg::TAPS - 1)) ? '0 : hp_r[ci] + 1'b1;
        if (hcnt_r[ci] != TW'(sfdm_pkg::TAPS)) hcnt_r[ci] <= hcnt_r[ci] + 1'b1;
      end
    end
  end

  // delay memory; entries not yet written since clear read as zero
  always_ff @(posedge clk) begin
    if (cmd.dly_wr) dmem[dwaddr] <= lpre_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.dly_rd) begin
      drd_r <= dmem[draddr];
      dv_r  <= full_r[ci] || (rptr_r[ci] < wptr_r[ci]);
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (cmd.fir_wr) hmem[hwaddr] <= rpre_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_rd) begin
      hdata_r <= hmem[hraddr];
      hv1_r   <= cmd.tap < hcnt_r[ci];
      coef1_r <= sfdm_pkg::GAIN_W'(sfdm_pkg::COEF_HALF[fs][kidx[3:0]]);
    end
    if (cmd.fir_wr) fslot_r <= hp_r[ci];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.tap_rd;
      v2_r <= v1_r;
    end
  end

  // shared multiplier; MAC beats take priority
  always_comb begin
    if (v1_r) begin
      mul_a = hv1_r ? hdata_r : '0;
      mul_b = coef1_r;
    end else begin
      case (cmd.mul_sel)
        sfdm_pkg::MUL_LPRE:  begin mul_a = left_r;  mul_b = sfdm_pkg::GL_PRE;  end
        sfdm_pkg::MUL_RPRE:  begin mul_a = right_r; mul_b = sfdm_pkg::GR_PRE;  end
        sfdm_pkg::MUL_DPOST: begin
          mul_a = dv_r ? drd_r : '0;
          mul_b = sfdm_pkg::GL_POST;
        end
        sfdm_pkg::MUL_RPOST: begin mul_a = fir_r;   mul_b = sfdm_pkg::GR_POST; end
        default:             begin mul_a = '0;      mul_b = '0;                end
      endcase
    end
  end

  // round half up then drop 16 fraction bits
  assign prod_rs  = prod_r + PDW'(32768);
  assign rnd_prod = prod_rs[SW+15:16];
  assign acc_rs   = acc_r + ACW'(32768);
  assign acc_sh   = acc_rs[ACW-1:16];

  always_comb begin
    if (!acc_sh[SHW-1] && (|acc_sh[SHW-1:SW-1])) fir_sat = SMAX;
    else if (acc_sh[SHW-1] && !(&acc_sh[SHW-1:SW-1])) fir_sat = SMIN;
    else fir_sat = acc_sh[SW-1:0];
  end

  assign mix_sum = {lp_r[SW-1], lp_r} + {rp_r[SW-1], rp_r};

  always_comb begin
    if (mix_sum[SW] != mix_sum[SW-1]) mix_sat = mix_sum[SW] ? SMIN : SMAX;
    else mix_sat = mix_sum[SW-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= PDW'(mul_a) * PDW'(mul_b);
    if (cmd.fir_wr) acc_r <= '0;
    else if (v2_r) acc_r <= acc_r + ACW'(prod_r);
    if (cmd.in_load) begin
      left_r  <= left_on ? in_left : '0;
      right_r <= right_on ? in_right : '0;
    end
    if (cmd.st_lpre) lpre_r <= rnd_prod;
    if (cmd.st_rpre) rpre_r <= rnd_prod;
    if (cmd.lp_pass) lp_r <= lpre_r;
    else if (cmd.st_lp) lp_r <= rnd_prod;
    if (cmd.fir_rnd) fir_r <= fir_sat;
    if (cmd.rp_zero) rp_r <= '0;
    else if (cmd.st_rp) rp_r <= rnd_prod;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel_r <= cmd.ch;
      out_mixed_r   <= mix_sat;
      out_last_r    <= cmd.out_last;
    end
  end

  assign stat.out_free   = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_mixed_sample = out_mixed_r;
  assign out_last         = out_last_r;

endmodule

>>> rtl/core/sfdm_chk.sv
// Port-level checks for the mixer, bound to the top level.
// Depends on sfdm_pkg and six_channel_fir_delay_mixer.
module sfdm_chk #(
  parameter int CHANNELS     = sfdm_pkg::DEF_CHANNELS,
  parameter int SAMPLE_WIDTH = sfdm_pkg::DEF_SAMPLE_WIDTH
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [sfdm_pkg::CH_W-1:0]       out_channel,
  input logic [SAMPLE_WIDTH-1:0]         out_mixed_sample,
  input logic                            out_last,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [sfdm_pkg::CFG_IDX_W-1:0]  cfg_index
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mixed_sample)
      && $stable(out_channel) && $stable(out_last))
    else $error("stalled output beat changed");

  a_out_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_channel < sfdm_pkg::CH_W'(CHANNELS))
    else $error("output channel out of range");

  // one item at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // state reload after a register write blocks input
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index < sfdm_pkg::CFG_NUM_REGS) |=> in_stall)
    else $error("input taken during state clear");

endmodule

bind six_channel_fir_delay_mixer sfdm_chk #(
  .CHANNELS    (CHANNELS),
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sfdm_chk (.*);
